@@ design/unbf_pkg.sv @@
// Shared constants and types of the user-id network block filter.
`default_nettype none

package unbf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int UID_W       = 31;
    localparam int ENTRY_W     = 9;
    localparam int ADDR_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ADDR_W-1:0] FAMILY_V4   = 16'd2;
    localparam logic [ADDR_W-1:0] FAMILY_V6   = 16'd10;
    localparam logic [ADDR_W-1:0] MIN_ADDR_LEN = 16'd2;
    localparam logic [UID_W-1:0]  LIMIT_RESET = 31'd10000;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BLOCKED   = 3'd1,
        STS_INVALID   = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE = 2'd0,
        REG_EXEMPT_UID    = 2'd1,
        REG_UID_LIMIT     = 2'd2
    } t_cfg_reg;

endpackage

`default_nettype wire

@@ design/uid_network_block_filter.sv @@
// Top level of the user-id network block filter.
//
// An ordered table of blocked user ids lives in one synchronous RAM. Each input
// transaction carries one operation: check an access, add a uid, remove a uid or
// clear the table; each produces exactly one result transaction with a status
// and the table count after the operation.
// Input and output channels use valid/ready. The block takes one operation at a
// time: o_in_ready is high only while no operation is in progress. A result sits
// in an output register, so the next operation is accepted while it waits.
// Checks decided by the registers or the address fields alone, adds and removes
// of uid zero, adds to a full table and clears go straight to the done state.
// Otherwise the table is walked one entry per cycle through the RAM read port; a
// remove walks up to the match, then moves each later entry one place lower, one
// read and one write per cycle, to close the gap.
// Configuration writes are accepted on their own channel in any cycle.
// Reset (synchronous, active low) empties the table and restores the register
// defaults; table contents are not cleared. A stalled receiver holds the result
// and the block idles in its done state until the output register frees up.
`default_nettype none

module uid_network_block_filter
    import unbf_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [1:0]               i_opcode,
    input  wire  [UID_W-1:0]         i_user_id,
    input  wire                      i_addr_present,
    input  wire  [ADDR_W-1:0]        i_addr_len,
    input  wire  [ADDR_W-1:0]        i_addr_family,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [2:0]               o_status,
    output logic [ENTRY_W-1:0]       o_entry_count,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    t_status               r_status, n_status;
    logic [UID_W-1:0]      r_uid, n_uid;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_ridx, n_ridx;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    logic [2:0]            r_out_status, n_out_status;
    logic [ENTRY_W-1:0]    r_out_count, n_out_count;
    logic                  r_enable, n_enable;
    logic [CFG_DATA_W-1:0] r_exempt, n_exempt;
    logic [UID_W-1:0]      r_limit, n_limit;

    logic                  hit;
    logic                  more;
    logic                  exempt_match;
    logic                  addr_blockable;
    logic                  rd_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [UID_W-1:0]      wr_data;
    logic [UID_W-1:0]      rd_data;
    logic [CNT_W+ENTRY_W-1:0] count_ext;

    unbf_ram #(
        .WIDTH (UID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ridx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // A read issued last cycle returns now; compare it against the operand.
    assign hit  = r_pend && (rd_data == r_uid);
    assign more = (r_ridx < r_count);

    // A negative exempt uid never matches, since user ids are never negative.
    assign exempt_match   = !r_exempt[CFG_DATA_W-1] &&
                            (r_exempt[UID_W-1:0] == i_user_id);
    assign addr_blockable = i_addr_present && (i_addr_len >= MIN_ADDR_LEN) &&
                            ((i_addr_family == FAMILY_V4) ||
                             (i_addr_family == FAMILY_V6));

    assign count_ext = {{ENTRY_W{1'b0}}, r_count};

    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = r_uid;
        case (r_state)
            ST_SCAN: begin
                rd_en = !hit && more;
                wr_en = !hit && !more && (r_op == OP_ADD);
            end
            ST_SHIFT: begin
                rd_en   = more;
                wr_en   = r_pend;
                wr_addr = r_pidx - IDX_W'(1);
                wr_data = rd_data;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_status     = r_status;
        n_uid        = r_uid;
        n_count      = r_count;
        n_ridx       = r_ridx;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_enable     = r_enable;
        n_exempt     = r_exempt;
        n_limit      = r_limit;

        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FILTER_ENABLE: n_enable = i_cfg_data[0];
                REG_EXEMPT_UID:    n_exempt = i_cfg_data;
                REG_UID_LIMIT:     n_limit  = i_cfg_data[UID_W-1:0];
                default: begin
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = t_opcode'(i_opcode);
                    n_uid    = i_user_id;
                    n_ridx   = '0;
                    n_pend   = 1'b0;
                    n_status = STS_OK;
                    n_state  = ST_DONE;
                    case (t_opcode'(i_opcode))
                        OP_CHECK: begin
                            if (r_enable && (r_count != '0) && !exempt_match &&
                                (i_user_id >= r_limit) && addr_blockable) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_ADD: begin
                            if (i_user_id == '0) begin
                                n_status = STS_INVALID;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_status = STS_FULL;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_user_id == '0) begin
                                n_status = STS_INVALID;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                    case (r_op)
                        OP_CHECK:  n_status = STS_BLOCKED;
                        OP_REMOVE: n_state  = ST_SHIFT;
                        default:   n_status = STS_OK;
                    endcase
                end else if (more) begin
                    n_pend = 1'b1;
                    n_pidx = r_ridx[IDX_W-1:0];
                    n_ridx = r_ridx + CNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                    case (r_op)
                        OP_ADD: begin
                            n_count  = r_count + CNT_W'(1);
                            n_status = STS_OK;
                        end
                        OP_REMOVE: n_status = STS_NOT_FOUND;
                        default:   n_status = STS_OK;
                    endcase
                end
            end
            ST_SHIFT: begin
                // Each returned entry is written one place lower.
                n_pend = more;
                if (more) begin
                    n_pidx = r_ridx[IDX_W-1:0];
                    n_ridx = r_ridx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = STS_OK;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = count_ext[ENTRY_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_exempt    <= '1;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_enable    <= n_enable;
            r_exempt    <= n_exempt;
            r_limit     <= n_limit;
        end
        r_op         <= n_op;
        r_status     <= n_status;
        r_uid        <= n_uid;
        r_ridx       <= n_ridx;
        r_pidx       <= n_pidx;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

@@ design/unbf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module unbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                                        i_clk,
    input  wire                                        i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                           i_wr_data,
    input  wire                                        i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/unbf_checker.sv @@
// Port-level checks of the block filter, bound to the top level.
`default_nettype none

module unbf_checker
    import unbf_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_ready,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input wire [2:0]             o_status,
    input wire [ENTRY_W-1:0]     o_entry_count
);

    localparam logic [CNT_W+ENTRY_W-1:0] DEPTH_EXT = (CNT_W+ENTRY_W)'(TABLE_DEPTH);

    // A waiting result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_entry_count)))
        else $error("result changed while stalled");

    // Only one operation is in progress at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an operation is in progress");

    // A full table reports the full depth.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STS_FULL)) |->
            (o_entry_count == DEPTH_EXT[ENTRY_W-1:0]))
        else $error("table full reported with wrong count");

    // An access is never blocked by an empty table.
    a_blocked_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STS_BLOCKED)) |-> (o_entry_count != '0))
        else $error("access blocked with an empty table");

    // No result directly after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind uid_network_block_filter unbf_checker u_unbf_checker (.*);

`default_nettype wire

@@ dv/uid_network_block_filter_tb.sv @@
// Self-checking testbench of the user-id network block filter with randomized traffic.
`default_nettype none

module uid_network_block_filter_tb;
    import unbf_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int POOL_N      = 16;
    localparam int TAIL_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        t_opcode           op;
        logic [UID_W-1:0]  uid;
        logic              present;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] fam;
    } t_access_op;

    typedef struct {
        t_status            status;
        logic [ENTRY_W-1:0] count;
        t_opcode            op;
        logic [UID_W-1:0]   uid;
    } t_answer;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [1:0]            i_opcode       = '0;
    logic [UID_W-1:0]      i_user_id      = '0;
    logic                  i_addr_present = 1'b0;
    logic [ADDR_W-1:0]     i_addr_len     = '0;
    logic [ADDR_W-1:0]     i_addr_family  = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [2:0]            o_status;
    logic [ENTRY_W-1:0]    o_entry_count;
    logic                  o_cfg_ready;

    // Mirror of the block: the ordered uid list and the three registers.
    logic [UID_W-1:0] blocklist[$];
    logic             filter_on   = 1'b0;
    logic [31:0]      exempt_bits = 32'hFFFF_FFFF;
    logic [UID_W-1:0] uid_floor   = LIMIT_RESET;

    t_access_op       ops_to_send[$];
    t_answer          answers_due[$];
    t_access_op       on_wire;
    t_answer          oldest;
    logic [UID_W-1:0] uid_pool[POOL_N];
    logic             idling_on = 1'b1;
    int               n_issued = 0;
    int               n_accepted = 0;
    int               send_gap = 0;
    int               stall_left = 0;
    int               err_count = 0;
    int               cycle_no = 0;

    uid_network_block_filter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_user_id      (i_user_id),
        .i_addr_present (i_addr_present),
        .i_addr_len     (i_addr_len),
        .i_addr_family  (i_addr_family),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        err_count++;
        $display("cycle %0d: mismatch: %s", cycle_no, what);
    endtask

    // Applies one operation to the mirrored table and returns the status and count it yields.
    function automatic t_answer apply_blocklist_op(input t_access_op a);
        t_answer r;
        int      pos;
        int      n;
        pos = -1;
        for (int i = 0; i < blocklist.size(); i++) begin
            if (pos < 0 && blocklist[i] == a.uid) begin
                pos = i;
            end
        end
        r.op     = a.op;
        r.uid    = a.uid;
        r.status = STS_OK;
        case (a.op)
            OP_CHECK: begin
                if (filter_on && blocklist.size() != 0 && {1'b0, a.uid} != exempt_bits &&
                    a.uid >= uid_floor && pos >= 0 && a.present && a.len >= MIN_ADDR_LEN &&
                    (a.fam == FAMILY_V4 || a.fam == FAMILY_V6)) begin
                    r.status = STS_BLOCKED;
                end
            end
            OP_ADD: begin
                // A full table is reported before the duplicate test.
                if (a.uid == '0) begin
                    r.status = STS_INVALID;
                end else if (blocklist.size() >= TABLE_DEPTH) begin
                    r.status = STS_FULL;
                end else if (pos < 0) begin
                    blocklist.push_back(a.uid);
                end
            end
            OP_REMOVE: begin
                if (a.uid == '0) begin
                    r.status = STS_INVALID;
                end else if (pos < 0) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    blocklist.delete(pos);
                end
            end
            default: begin
                blocklist.delete();
            end
        endcase
        n = blocklist.size();
        r.count = n[ENTRY_W-1:0];
        return r;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic t_access_op random_op();
        t_access_op a;
        int         r;
        r = $urandom_range(0, 99);
        a.op = (r < 45) ? OP_CHECK : (r < 72) ? OP_ADD : (r < 96) ? OP_REMOVE : OP_CLEAR;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            a.uid = uid_pool[$urandom_range(0, POOL_N - 1)];
        end else if (r < 85) begin
            a.uid = UID_W'($urandom_range(0, 12000));
        end else if (r < 90) begin
            a.uid = '0;
        end else begin
            a.uid = UID_W'($urandom());
        end
        if ($urandom_range(0, 99) < 70) begin
            // A real access in one of the two families: a length of 2 to 28, or any value.
            a.present = 1'b1;
            a.len     = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom())
                                                    : ADDR_W'($urandom_range(2, 28));
            a.fam     = ($urandom_range(0, 1) == 1) ? FAMILY_V4 : FAMILY_V6;
        end else begin
            a.present = 1'($urandom_range(0, 1));
            a.len     = ($urandom_range(0, 1) == 1) ? ADDR_W'($urandom_range(0, 2))
                                                    : ADDR_W'($urandom());
            a.fam     = ($urandom_range(0, 1) == 1) ? ADDR_W'($urandom_range(0, 12))
                                                    : ADDR_W'($urandom());
        end
        return a;
    endfunction

    task automatic queue_op(input t_opcode op, input logic [UID_W-1:0] uid,
                            input logic present, input logic [ADDR_W-1:0] len,
                            input logic [ADDR_W-1:0] fam);
        t_access_op a;
        a.op      = op;
        a.uid     = uid;
        a.present = present;
        a.len     = len;
        a.fam     = fam;
        ops_to_send.push_back(a);
        n_issued++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            ops_to_send.push_back(random_op());
            n_issued++;
        end
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk); while (n_issued != n_accepted || answers_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FILTER_ENABLE: filter_on   = val[0];
            REG_EXEMPT_UID:    exempt_bits = val;
            REG_UID_LIMIT:     uid_floor   = val[UID_W-1:0];
            default: ;
        endcase
    endtask

    // Input side: one operation transaction at a time, with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                answers_due.push_back(apply_blocklist_op(on_wire));
                n_accepted++;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (ops_to_send.size() != 0) begin
                on_wire = ops_to_send.pop_front();
                i_opcode       <= on_wire.op;
                i_user_id      <= on_wire.uid;
                i_addr_present <= on_wire.present;
                i_addr_len     <= on_wire.len;
                i_addr_family  <= on_wire.fam;
                i_in_valid     <= 1'b1;
                send_gap = idle_cycles();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: check every result transaction and stall the block at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    flag_error($sformatf("status %0d count %0d with no operation outstanding",
                                         o_status, o_entry_count));
                end else begin
                    oldest = answers_due.pop_front();
                    if (o_status !== oldest.status) begin
                        flag_error($sformatf("op %0d uid %0d: status %0d, want %0d",
                                             oldest.op, oldest.uid, o_status, oldest.status));
                    end
                    if (o_entry_count !== oldest.count) begin
                        flag_error($sformatf("op %0d uid %0d: count %0d, want %0d",
                                             oldest.op, oldest.uid, o_entry_count,
                                             oldest.count));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) begin
                    stall_left = idle_cycles();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int n_new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at their reset values: filtering is off.
        queue_op(OP_ADD,    '0,           1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_REMOVE, '0,           1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_REMOVE, 31'd12345,    1'b0, 16'd0, 16'd0);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_ADD,    31'd50000,    1'b0, 16'd0, 16'd0);
        queue_op(OP_ADD,    31'd50000,    1'b0, 16'd0, 16'd0);
        queue_op(OP_ADD,    '1,           1'b0, 16'd0, 16'd0);
        queue_op(OP_ADD,    31'd1,        1'b0, 16'd0, 16'd0);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2, FAMILY_V4);
        wait_quiet();

        write_reg(REG_FILTER_ENABLE, 32'd1);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2,      FAMILY_V4);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'hFFFF,   FAMILY_V6);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd1,      FAMILY_V4);
        queue_op(OP_CHECK,  31'd50000,    1'b0, 16'd2,      FAMILY_V4);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2,      16'd3);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2,      16'hFFFF);
        queue_op(OP_CHECK,  '1,           1'b1, 16'd2,      FAMILY_V6);
        queue_op(OP_CHECK,  31'd1,        1'b1, 16'd2,      FAMILY_V4);
        queue_op(OP_CHECK,  31'd60000,    1'b1, 16'd2,      FAMILY_V4);
        wait_quiet();

        write_reg(REG_EXEMPT_UID, 32'd50000);
        queue_op(OP_CHECK,  31'd50000,    1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_CHECK,  '1,           1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_REMOVE, 31'd50000,    1'b0, 16'd0, 16'd0);
        queue_op(OP_CHECK,  '1,           1'b1, 16'd2, FAMILY_V4);
        queue_op(OP_REMOVE, 31'd50000,    1'b0, 16'd0, 16'd0);
        queue_op(OP_CLEAR,  31'd50000,    1'b0, 16'd0, 16'd0);
        queue_op(OP_CHECK,  '1,           1'b1, 16'd2, FAMILY_V4);
        wait_quiet();

        // A write to the unused index must leave every register alone.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 13; ph++) begin
            idling_on = (ph % 3 != 1);
            if (ph == 6) begin
                // Fill the table to the last slot, then work on it while it is full.
                write_reg(REG_FILTER_ENABLE, 32'd1);
                write_reg(REG_EXEMPT_UID, 32'hFFFF_FFFF);
                write_reg(REG_UID_LIMIT, 32'd0);
                n_new = TABLE_DEPTH - blocklist.size();
                for (int k = 0; k < n_new + 2; k++) begin
                    queue_op(OP_ADD, UID_W'(32'h5A00_0001 + 3 * k), 1'b0, 16'd0, 16'd0);
                end
                for (int k = 0; k < POOL_N; k++) begin
                    uid_pool[k] = UID_W'(32'h5A00_0001 + 3 * (k * 17 % n_new));
                end
                uid_pool[POOL_N - 1] = UID_W'(32'h5A00_0001 + 3 * (n_new - 1));
                queue_op(OP_ADD,   uid_pool[0], 1'b0, 16'd0, 16'd0);
                queue_op(OP_ADD,   '0,          1'b0, 16'd0, 16'd0);
                queue_op(OP_CHECK, uid_pool[POOL_N - 1], 1'b1, 16'd16, FAMILY_V6);
                queue_random(40);
                queue_op(OP_CLEAR, '0, 1'b0, 16'd0, 16'd0);
            end else begin
                for (int k = 0; k < POOL_N; k++) begin
                    case (k % 4)
                        0, 1:    uid_pool[k] = UID_W'($urandom());
                        2:       uid_pool[k] = UID_W'($urandom_range(9990, 20000));
                        default: uid_pool[k] = UID_W'($urandom_range(1, 9999));
                    endcase
                end
                uid_pool[0] = '1;
                write_reg(REG_FILTER_ENABLE, {31'($urandom()), ph % 5 != 2});
                case ($urandom_range(0, 4))
                    0: write_reg(REG_EXEMPT_UID, 32'hFFFF_FFFF);
                    1: write_reg(REG_EXEMPT_UID, {1'b0, uid_pool[$urandom_range(0, POOL_N - 1)]});
                    2: write_reg(REG_EXEMPT_UID, {1'b1, 31'($urandom())});
                    3: write_reg(REG_EXEMPT_UID, 32'h7FFF_FFFF);
                    default: write_reg(REG_EXEMPT_UID, 32'd0);
                endcase
                case (ph % 4)
                    0: write_reg(REG_UID_LIMIT, {1'($urandom_range(0, 1)), 31'd0});
                    1: write_reg(REG_UID_LIMIT, 32'd10000);
                    2: write_reg(REG_UID_LIMIT, {1'($urandom_range(0, 1)), 31'h7FFF_FFFF});
                    default: write_reg(REG_UID_LIMIT, $urandom_range(0, 20000));
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(REG_UNUSED, $urandom());
                end
                queue_random(75);
            end
            wait_quiet();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
design/unbf_pkg.sv
design/unbf_ram.sv
design/uid_network_block_filter.sv
design/unbf_checker.sv
dv/uid_network_block_filter_tb.sv
